@@ rtl/grid_line_of_sight_check_core_defines.svh @@
// Assertion helpers for the line of sight checker
`ifndef GRID_LINE_OF_SIGHT_CHECK_CORE_DEFINES_SVH
`define GRID_LINE_OF_SIGHT_CHECK_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define GLOS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("glos: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define GLOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("glos: next-cycle check failed");

`endif

@@ rtl/glos_pkg.sv @@
package glos_pkg;

  // Grid geometry and field widths
  localparam int GRID_W = 64;
  localparam int GRID_H = 32;
  localparam int XW     = 6;
  localparam int YW     = 5;
  localparam int ROW_W  = 64;
  // Width of the ratio cross products
  localparam int PW     = XW + YW + 1;

  // Item kinds
  localparam logic KIND_ROW_WRITE = 1'b0;
  localparam logic KIND_QUERY     = 1'b1;

  // Walker sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_RESP
  } state_t;

  // Query fields latched by the walker
  typedef struct packed {
    logic [XW-1:0] start_x;
    logic [YW-1:0] start_y;
    logic [XW-1:0] target_x;
    logic [YW-1:0] target_y;
    logic [XW-1:0] avoid_x;
    logic [YW-1:0] avoid_y;
  } query_t;

  // Map read request from walker to RAM
  typedef struct packed {
    logic          en;
    logic [YW-1:0] addr;
  } rd_req_t;

  // Walker answer towards the output register
  typedef struct packed {
    logic valid;
    logic reachable;
  } result_t;

endpackage

@@ rtl/glos_if.sv @@
// Input channel: row writes and path queries
interface glos_in_if;
  import glos_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [YW-1:0]    row_index;
  logic [ROW_W-1:0] row_bits;
  logic [XW-1:0]    start_x;
  logic [YW-1:0]    start_y;
  logic [XW-1:0]    target_x;
  logic [YW-1:0]    target_y;
  logic [XW-1:0]    avoid_x;
  logic [YW-1:0]    avoid_y;

  modport source (
    output valid, kind, row_index, row_bits, start_x, start_y,
           target_x, target_y, avoid_x, avoid_y,
    input  ready
  );

  modport sink (
    input  valid, kind, row_index, row_bits, start_x, start_y,
           target_x, target_y, avoid_x, avoid_y,
    output ready
  );
endinterface

// Result channel: one answer per query
interface glos_out_if;
  logic valid;
  logic ready;
  logic reachable;

  modport source (output valid, reachable, input ready);
  modport sink (input valid, reachable, output ready);
endinterface

@@ rtl/grid_line_of_sight_check_core.sv @@
// Row write: no result; the next item may follow at once.
// Query: the start row is read on acceptance, then each path cell is checked in turn
// (|dx|+|dy|+1 at most, fewer if a cell fails); the answer goes out via a register.
// Rate is set by the single read port of the map RAM: one row read per cell.
// Reset (synchronous, active low) clears control only; map rows are undefined
// until written and get no clearing pass.
`include "grid_line_of_sight_check_core_defines.svh"

module grid_line_of_sight_check_core (
  input logic       clk,
  input logic       rst_n,
  glos_in_if.sink   in_ch,
  glos_out_if.source out_ch
);
  import glos_pkg::*;

  logic             in_acc;
  logic             q_start;
  logic             row_we;
  logic             slot_free;
  logic             walk_idle;
  query_t           query;
  rd_req_t          rd_req;
  result_t          res;
  logic [ROW_W-1:0] rd_data;
  logic             out_valid_r, out_valid_nxt;
  logic             out_reach_r;

  // Input handshake and item decode
  always_comb begin
    in_ch.ready    = walk_idle;
    in_acc         = in_ch.valid && in_ch.ready;
    q_start        = in_acc && (in_ch.kind == KIND_QUERY);
    row_we         = in_acc && (in_ch.kind == KIND_ROW_WRITE) &&
                     ({1'b0, in_ch.row_index} < (YW+1)'(GRID_H));
    query.start_x  = in_ch.start_x;
    query.start_y  = in_ch.start_y;
    query.target_x = in_ch.target_x;
    query.target_y = in_ch.target_y;
    query.avoid_x  = in_ch.avoid_x;
    query.avoid_y  = in_ch.avoid_y;
  end

  // Occupancy map
  glos_ram #(
    .WIDTH (ROW_W),
    .DEPTH (GRID_H)
  ) u_map (
    .clk   (clk),
    .we    (row_we),
    .waddr (in_ch.row_index),
    .wdata (in_ch.row_bits),
    .re    (rd_req.en),
    .raddr (rd_req.addr),
    .rdata (rd_data)
  );

  // Path walker
  glos_walk u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (q_start),
    .query    (query),
    .rd_data  (rd_data),
    .res_take (slot_free),
    .rd_req   (rd_req),
    .res      (res),
    .idle     (walk_idle)
  );

  // Output register
  always_comb begin
    slot_free = !out_valid_r || out_ch.ready;
    if (res.valid && slot_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
    out_ch.valid     = out_valid_r;
    out_ch.reachable = out_reach_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && slot_free) begin
      out_reach_r <= res.reachable;
    end
  end

  // A query keeps the input closed on the following cycle
  `GLOS_ASSERT_NEXT(a_query_busy, clk, rst_n, q_start, !in_ch.ready)
  // A row write leaves the block ready on the following cycle
  `GLOS_ASSERT_NEXT(a_write_quick, clk, rst_n, in_acc && !q_start, in_ch.ready)
  // An answer not taken is still offered next cycle
  `GLOS_ASSERT_NEXT(a_res_held, clk, rst_n, res.valid && !slot_free, res.valid)
  // No map read while a finished answer waits
  `GLOS_ASSERT_NOW(a_no_read_resp, clk, rst_n, res.valid, !rd_req.en)

endmodule

@@ rtl/glos_ram.sv @@
// Simple dual-port RAM, one write and one registered read port
module glos_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/glos_walk.sv @@
// Path walker: one cell per cycle, one map row read per cell
module glos_walk (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  glos_pkg::query_t         query,
  input  logic [glos_pkg::ROW_W-1:0] rd_data,
  input  logic                     res_take,
  output glos_pkg::rd_req_t        rd_req,
  output glos_pkg::result_t        res,
  output logic                     idle
);
  import glos_pkg::*;

  state_t        state_r, state_nxt;
  logic [XW-1:0] cx_r, cx_nxt;
  logic [YW-1:0] cy_r, cy_nxt;
  logic [XW-1:0] aw_r, aw_nxt;
  logic [YW-1:0] ah_r, ah_nxt;
  logic [XW-1:0] mx_r, mx_nxt;
  logic [YW-1:0] my_r, my_nxt;
  logic [XW-1:0] avx_r, avx_nxt;
  logic [YW-1:0] avy_r, avy_nxt;
  logic          negx_r, negx_nxt;
  logic          negy_r, negy_nxt;
  logic          res_r, res_nxt;

  logic          cell_ok;
  logic          at_target;
  logic          fin;
  logic          step_x;
  logic [XW:0]   mx_inc;
  logic [YW:0]   my_inc;
  logic [PW-1:0] prod_h;
  logic [PW-1:0] prod_w;
  logic [XW-1:0] cx_step;
  logic [YW-1:0] cy_step;

  // Current cell: in grid, not the avoided cell, free in the row just read
  always_comb begin
    cell_ok = ({1'b0, cx_r} < (XW+1)'(GRID_W)) &&
              ({1'b0, cy_r} < (YW+1)'(GRID_H)) &&
              !((cx_r == avx_r) && (cy_r == avy_r)) &&
              !rd_data[cx_r];
    at_target = (mx_r == aw_r) && (my_r == ah_r);
    fin       = !cell_ok || at_target;
  end

  // Step choice: x when y is done, or x progress ratio is the smaller
  always_comb begin
    mx_inc  = {1'b0, mx_r} + (XW+1)'(1);
    my_inc  = {1'b0, my_r} + (YW+1)'(1);
    prod_h  = PW'(ah_r) * PW'(mx_inc);
    prod_w  = PW'(aw_r) * PW'(my_inc);
    step_x  = (my_r == ah_r) ||
              ((aw_r != '0) && ((ah_r == '0) || (prod_h < prod_w)));
    cx_step = negx_r ? (cx_r - XW'(1)) : (cx_r + XW'(1));
    cy_step = negy_r ? (cy_r - YW'(1)) : (cy_r + YW'(1));
  end

  // Datapath next values
  always_comb begin
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    aw_nxt   = aw_r;
    ah_nxt   = ah_r;
    mx_nxt   = mx_r;
    my_nxt   = my_r;
    avx_nxt  = avx_r;
    avy_nxt  = avy_r;
    negx_nxt = negx_r;
    negy_nxt = negy_r;
    res_nxt  = res_r;
    if ((state_r == ST_IDLE) && start) begin
      cx_nxt   = query.start_x;
      cy_nxt   = query.start_y;
      negx_nxt = query.target_x < query.start_x;
      negy_nxt = query.target_y < query.start_y;
      aw_nxt   = negx_nxt ? (query.start_x - query.target_x)
                          : (query.target_x - query.start_x);
      ah_nxt   = negy_nxt ? (query.start_y - query.target_y)
                          : (query.target_y - query.start_y);
      mx_nxt   = '0;
      my_nxt   = '0;
      avx_nxt  = query.avoid_x;
      avy_nxt  = query.avoid_y;
    end else if (state_r == ST_WALK) begin
      res_nxt = cell_ok;
      if (step_x) begin
        cx_nxt = cx_step;
        mx_nxt = mx_inc[XW-1:0];
      end else begin
        cy_nxt = cy_step;
        my_nxt = my_inc[YW-1:0];
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (fin) begin
          state_nxt = res_take ? ST_IDLE : ST_RESP;
        end
      end
      ST_RESP: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    rd_req.en     = 1'b0;
    rd_req.addr   = cy_r;
    res.valid     = 1'b0;
    res.reachable = res_r;
    idle          = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        idle        = 1'b1;
        rd_req.en   = start;
        rd_req.addr = query.start_y;
      end
      ST_WALK: begin
        rd_req.en     = !fin;
        rd_req.addr   = step_x ? cy_r : cy_step;
        res.valid     = fin;
        res.reachable = cell_ok;
      end
      ST_RESP: begin
        res.valid = 1'b1;
      end
      default: begin
        idle = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    aw_r   <= aw_nxt;
    ah_r   <= ah_nxt;
    mx_r   <= mx_nxt;
    my_r   <= my_nxt;
    avx_r  <= avx_nxt;
    avy_r  <= avy_nxt;
    negx_r <= negx_nxt;
    negy_r <= negy_nxt;
    res_r  <= res_nxt;
  end

endmodule
